// ----- hdl/dpc_pkg.sv -----
// Shared types, constants and register codes of the depth to point cloud block.
package dpc_pkg;

  localparam int unsigned EFF_W = 13;
  localparam int unsigned H_W = EFF_W + 1;
  localparam int unsigned DEN_W = 33;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam logic [30:0] Z_NUMER = 31'd1677721600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_DEPTH_GAIN    = 3'd2,
    REG_DEPTH_OFFSET  = 3'd3,
    REG_NEAR_OFFSET   = 3'd4,
    REG_LATERAL_SCALE = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL1,
    BK_MUL2,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [10:0]       frame_width;
    logic [10:0]       frame_height;
    logic [15:0]       depth_gain;
    logic [23:0]       depth_offset;
    logic signed [9:0] near_offset;
    logic [15:0]       lateral_scale;
  } cfg_t;

  typedef struct packed {
    logic signed [DEN_W-1:0] den;
    logic signed [H_W-1:0]   hx;
    logic signed [H_W-1:0]   hy;
    logic                    frame_end;
  } item_t;

endpackage

// ----- hdl/dpc_front.sv -----
// Front end: accepts samples, tracks the raster position and forms the denominator.
module dpc_front import dpc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        take_i,
  input  logic [15:0] depth_raw_i,
  input  logic        frame_start_i,
  output item_t       item_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [H_W-1:0] w, h, c0, r0, c1, r1, r2, cn, rn;
  logic [31:0] prod;

  always_comb begin
    if (cfg_i.frame_width == 11'd0) begin
      w = H_W'(1);
    end else if (H_W'(cfg_i.frame_width) > H_W'(MAX_WIDTH)) begin
      w = H_W'(MAX_WIDTH);
    end else begin
      w = H_W'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == 11'd0) begin
      h = H_W'(1);
    end else if (H_W'(cfg_i.frame_height) > H_W'(MAX_HEIGHT)) begin
      h = H_W'(MAX_HEIGHT);
    end else begin
      h = H_W'(cfg_i.frame_height);
    end

    c0 = frame_start_i ? '0 : H_W'(col_q);
    r0 = frame_start_i ? '0 : H_W'(row_q);
    if (c0 >= w) begin
      c1 = '0;
      r1 = r0 + H_W'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= h) ? '0 : r1;

    cn = c1 + H_W'(1);
    rn = r2 + H_W'(1);
    if (cn >= w) begin
      col_d = '0;
      row_d = (rn >= h) ? '0 : rn[RW-1:0];
    end else begin
      col_d = cn[CW-1:0];
      row_d = r2[RW-1:0];
    end

    prod = 32'(cfg_i.depth_gain) * 32'(depth_raw_i);
    item_o.den = $signed(DEN_W'(cfg_i.depth_offset)) - $signed(DEN_W'(prod));
    item_o.hx = $signed(w - (c1 << 1));
    item_o.hy = $signed((r2 << 1) - h);
    item_o.frame_end = (c1 == w - H_W'(1)) && (r2 == h - H_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (take_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ----- hdl/dpc_fifo.sv -----
// Two-entry queue between the front end and the arithmetic back end.
module dpc_fifo import dpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t data_o
);

  item_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/dpc_back.sv -----
// Back end: iterative depth division, lateral scaling and the output register.
module dpc_back import dpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               empty_i,
  input  item_t              item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [17:0] x_pos_o,
  output logic signed [17:0] y_pos_o,
  output logic [15:0]        z_pos_o,
  output logic               point_valid_o,
  output logic               frame_end_o
);

  typedef struct packed {
    logic [17:0] val;
    logic        sat;
  } lat_t;

  function automatic lat_t lat_round(input logic [45:0] mag, input logic neg);
    logic [46:0] s;
    logic [21:0] r;
    lat_t res;
    s = 47'(mag) + 47'(1 << 24);
    r = s[46:25];
    res.sat = 1'b0;
    if (neg) begin
      if (r > 22'd131072) begin
        res.sat = 1'b1;
        res.val = 18'h20000;
      end else begin
        res.val = 18'(-r);
      end
    end else if (r > 22'd131071) begin
      res.sat = 1'b1;
      res.val = 18'h1FFFF;
    end else begin
      res.val = r[17:0];
    end
    return res;
  endfunction

  back_state_e state_q, state_d;
  logic [23:0] den_q;
  logic [24:0] rem_q;
  logic [15:0] nlo_q, z_q;
  logic [3:0] cnt_q;
  logic ok_q, fe_q, negx_q, negy_q;
  logic signed [H_W-1:0] hx_q, hy_q;
  logic [32:0] p1_q;
  logic [12:0] mhx_q, mhy_q;
  logic [45:0] magx_q, magy_q;
  logic out_valid_q;
  logic [17:0] x_q, y_q;
  logic [15:0] zo_q;
  logic pv_q, fo_q;

  logic pos, ovf, ge, load_out;
  logic [30:0] num;
  logic [24:0] rs;
  logic signed [17:0] zn;
  logic [16:0] mz;
  lat_t lx, ly;

  assign out_valid_o = out_valid_q;
  assign x_pos_o = $signed(x_q);
  assign y_pos_o = $signed(y_q);
  assign z_pos_o = zo_q;
  assign point_valid_o = pv_q;
  assign frame_end_o = fo_q;

  always_comb begin
    pos = !item_i.den[DEN_W-1] && (item_i.den != '0);
    num = Z_NUMER + 31'(item_i.den[23:1]);
    ovf = {9'd0, num} >= {item_i.den[23:0], 16'd0};
    rs = {rem_q[23:0], nlo_q[15]};
    ge = rs >= {1'b0, den_q};
    zn = $signed({2'b00, z_q}) + 18'(signed'({cfg_i.near_offset, 4'd0}));
    mz = zn[17] ? 17'(-zn) : zn[16:0];
    lx = lat_round(magx_q, negx_q);
    ly = lat_round(magy_q, negy_q);
    load_out = (state_q == BK_DONE) && (!out_valid_q || !out_stall_i);
    pop_o = 1'b0;
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          state_d = (pos && !ovf) ? BK_DIV : BK_MUL1;
        end
      end
      BK_DIV: begin
        if (cnt_q == 4'd15) begin
          state_d = BK_MUL1;
        end
      end
      BK_MUL1: state_d = BK_MUL2;
      BK_MUL2: state_d = BK_DONE;
      BK_DONE: begin
        if (load_out) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        den_q <= item_i.den[23:0];
        hx_q <= item_i.hx;
        hy_q <= item_i.hy;
        fe_q <= item_i.frame_end;
        rem_q <= {10'd0, num[30:16]};
        nlo_q <= num[15:0];
        cnt_q <= 4'd0;
        if (pos && !ovf) begin
          z_q <= 16'd0;
          ok_q <= 1'b1;
        end else begin
          z_q <= 16'hFFFF;
          ok_q <= 1'b0;
        end
      end
      BK_DIV: begin
        rem_q <= ge ? rs - {1'b0, den_q} : rs;
        z_q <= {z_q[14:0], ge};
        nlo_q <= {nlo_q[14:0], 1'b0};
        cnt_q <= cnt_q + 4'd1;
      end
      BK_MUL1: begin
        p1_q <= 33'(mz) * 33'(cfg_i.lateral_scale);
        mhx_q <= hx_q[H_W-1] ? 13'(-hx_q) : hx_q[12:0];
        mhy_q <= hy_q[H_W-1] ? 13'(-hy_q) : hy_q[12:0];
        negx_q <= hx_q[H_W-1] ^ zn[17];
        negy_q <= hy_q[H_W-1] ^ zn[17];
      end
      BK_MUL2: begin
        magx_q <= 46'(p1_q) * 46'(mhx_q);
        magy_q <= 46'(p1_q) * 46'(mhy_q);
      end
      default: ;
    endcase
    if (load_out) begin
      x_q <= lx.val;
      y_q <= ly.val;
      zo_q <= z_q;
      pv_q <= ok_q && !lx.sat && !ly.sat;
      fo_q <= fe_q;
    end
  end

endmodule

// ----- hdl/depth_to_point_cloud_core.sv -----
// Top level of the depth to point cloud converter.
// The input channel takes one raw depth sample per word together with a
// frame start flag; the block keeps its own column and row counters.
// The output channel gives one point per input word: x, y, z, a validity
// flag and a flag on the last pixel of the frame.
// Both channels move a word at an edge where valid is high and stall low.
// Configuration words are written through a valid/ready port that is
// always ready; writes are meant to happen while the block is idle.
// A word whose depth goes through the 16-step shift and subtract divider
// passes the pop state, the divider, the two lateral multiplier stages
// and the done state in turn before it reaches the output register; the
// back end takes no new word until the last leaves the done state. A word
// whose denominator is not positive or whose depth overflows skips the divider.
// The front end and a two-word queue accept words while the back end works;
// input stall rises when the queue is full.
// Reset clears the counters, the queue and the output valid flag and loads
// the default camera settings.
// While the output is stalled the result holds and the back end waits.
module depth_to_point_cloud_core import dpc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [15:0]           depth_raw_i,
  input  logic                  frame_start_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [17:0]    x_pos_o,
  output logic signed [17:0]    y_pos_o,
  output logic [15:0]           z_pos_o,
  output logic                  point_valid_o,
  output logic                  frame_end_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  item_t front_item, head_item;
  logic full, empty, pop, take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = full;
  assign take = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width <= 11'd640;
      cfg_q.frame_height <= 11'd480;
      cfg_q.depth_gain <= 16'd3219;
      cfg_q.depth_offset <= 24'd3491758;
      cfg_q.near_offset <= -10'sd10;
      cfg_q.lateral_scale <= 16'd35232;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:   cfg_q.frame_width <= cfg_data_i[10:0];
        REG_FRAME_HEIGHT:  cfg_q.frame_height <= cfg_data_i[10:0];
        REG_DEPTH_GAIN:    cfg_q.depth_gain <= cfg_data_i[15:0];
        REG_DEPTH_OFFSET:  cfg_q.depth_offset <= cfg_data_i;
        REG_NEAR_OFFSET:   cfg_q.near_offset <= $signed(cfg_data_i[9:0]);
        REG_LATERAL_SCALE: cfg_q.lateral_scale <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  dpc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .take_i       (take),
    .depth_raw_i  (depth_raw_i),
    .frame_start_i(frame_start_i),
    .item_o       (front_item)
  );

  dpc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (take),
    .data_i (front_item),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (head_item)
  );

  dpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .empty_i      (empty),
    .item_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .x_pos_o      (x_pos_o),
    .y_pos_o      (y_pos_o),
    .z_pos_o      (z_pos_o),
    .point_valid_o(point_valid_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

// ----- verif/depth_to_point_cloud_core_tb.sv -----
// Self-checking testbench of the depth to point cloud converter core.
module depth_to_point_cloud_core_tb;
  import dpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned FRAME_MAX_W = DEF_MAX_WIDTH;
  localparam int unsigned FRAME_MAX_H = DEF_MAX_HEIGHT;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam longint Z_SAT = 65535;
  localparam longint XY_HI = 131071;
  localparam longint XY_LO = -131072;

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic [15:0]        z;
    logic               ok;
    logic               last;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] depth_raw = '0;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [17:0] x_pos;
  logic signed [17:0] y_pos;
  logic [15:0] z_pos;
  logic point_valid;
  logic frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t cam;
  int unsigned col_cnt;
  int unsigned row_cnt;
  point_t expected_points[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit idle_en = 1'b1;

  depth_to_point_cloud_core i_dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .depth_raw_i(depth_raw),
    .frame_start_i(frame_start),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .x_pos_o(x_pos),
    .y_pos_o(y_pos),
    .z_pos_o(z_pos),
    .point_valid_o(point_valid),
    .frame_end_o(frame_end),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("depth_to_point_cloud_core test failed");
      $finish;
    end
  end

  function automatic int unsigned eff_size(int unsigned v, int unsigned vmax);
    if (v == 0) return 1;
    if (v > vmax) return vmax;
    return v;
  endfunction

  // Scales a half-pixel offset and a Q.4 depth into a saturated Q.4 coordinate.
  function automatic longint lateral_cm(longint h, longint zn, output bit sat);
    bit neg;
    longint unsigned mag;
    longint unsigned r;
    neg = (h < 0) != (zn < 0);
    mag = longint'(h < 0 ? -h : h) * longint'(zn < 0 ? -zn : zn) * cam.lateral_scale;
    r = (mag + (64'd1 << 24)) >> 25;
    sat = 1'b0;
    if (neg) begin
      if (r > 131072) begin
        sat = 1'b1;
        return XY_LO;
      end
      return -longint'(r);
    end
    if (r > 131071) begin
      sat = 1'b1;
      return XY_HI;
    end
    return longint'(r);
  endfunction

  function automatic point_t project_sample(logic [15:0] d, logic fs);
    int unsigned w;
    int unsigned ht;
    int unsigned col;
    int unsigned row;
    longint den;
    longint z;
    longint zn;
    longint xv;
    longint yv;
    bit sx;
    bit sy;
    point_t p;
    w = eff_size(cam.frame_width, FRAME_MAX_W);
    ht = eff_size(cam.frame_height, FRAME_MAX_H);
    p.ok = 1'b1;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= ht) row_cnt = 0;
    col = col_cnt;
    row = row_cnt;
    den = longint'(cam.depth_offset) - longint'(cam.depth_gain) * longint'(d);
    if (den <= 0) begin
      z = Z_SAT;
      p.ok = 1'b0;
    end else begin
      z = ((longint'(1600) << 20) + den / 2) / den;
      if (z > Z_SAT) begin
        z = Z_SAT;
        p.ok = 1'b0;
      end
    end
    zn = z + 16 * longint'(cam.near_offset);
    xv = lateral_cm(longint'(w) - 2 * longint'(col), zn, sx);
    yv = lateral_cm(2 * longint'(row) - longint'(ht), zn, sy);
    if (sx || sy) p.ok = 1'b0;
    p.x = xv[17:0];
    p.y = yv[17:0];
    p.z = z[15:0];
    p.last = (col == w - 1) && (row == ht - 1);
    col_cnt = col + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = row + 1;
      if (row_cnt >= ht) row_cnt = 0;
    end
    return p;
  endfunction

  task automatic send_sample(logic [15:0] d, logic fs);
    in_valid <= 1'b1;
    depth_raw <= d;
    frame_start <= fs;
    do @(posedge clk); while (in_stall);
    expected_points.push_back(project_sample(d, fs));
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:   cam.frame_width = val[10:0];
      REG_FRAME_HEIGHT:  cam.frame_height = val[10:0];
      REG_DEPTH_GAIN:    cam.depth_gain = val[15:0];
      REG_DEPTH_OFFSET:  cam.depth_offset = val[23:0];
      REG_NEAR_OFFSET:   cam.near_offset = val[9:0];
      REG_LATERAL_SCALE: cam.lateral_scale = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_camera(int unsigned w, int unsigned h, int unsigned g,
                            int unsigned o, int n, int unsigned s);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_DEPTH_GAIN, CFG_DATA_W'(g));
    write_reg(REG_DEPTH_OFFSET, CFG_DATA_W'(o));
    write_reg(REG_NEAR_OFFSET, CFG_DATA_W'(n & 10'h3ff));
    write_reg(REG_LATERAL_SCALE, CFG_DATA_W'(s));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_default_camera();
    logic [15:0] depths[10] = '{16'd0, 16'd1, 16'd500, 16'd1000, 16'd1084, 16'd1085,
                                16'hffff, 16'h8000, 16'h7fff, 16'd300};
    foreach (depths[i]) send_sample(depths[i], i == 3);
  endtask

  task automatic test_extremes();
    set_camera(0, 0, 0, 24'hffffff, -512, 65535);
    send_sample(16'd0, 1'b0);
    send_sample(16'hffff, 1'b1);
    set_camera(1024, 1024, 0, 1677, 511, 65535);
    send_sample(16'd7, 1'b1);
    send_sample(16'd9, 1'b0);
    set_camera(2047, 2047, 65535, 0, 0, 0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd1, 1'b0);
    wait_idle();
    write_reg(REG_SPARE_A, 24'h000001);
    write_reg(REG_SPARE_B, 24'hffffff);
    cfg_valid <= 1'b0;
    set_camera(3, 2, 65535, 24'hffffff, 0, 65535);
    for (int i = 0; i < 8; i++) send_sample(16'd255, i == 0);
  endtask

  task automatic test_random_frames(int unsigned phases);
    int unsigned w;
    int unsigned h;
    int unsigned g;
    int unsigned o;
    for (int p = 0; p < phases; p++) begin
      if (p == phases - 2) idle_en = 1'b0;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 9);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 6);
      if (p % 2 == 0) begin
        g = $urandom_range(0, 255);
        o = $urandom_range(g * 65535, 24'hffffff);
      end else begin
        g = $urandom_range(0, 65535);
        o = $urandom_range(0, 24'hffffff);
      end
      set_camera(w, h, g, o, int'($urandom_range(0, 1023)) - 512, $urandom_range(0, 65535));
      for (int i = 0; i < 100; i++) begin
        send_sample(16'($urandom_range(0, 65535)), $urandom_range(0, 29) == 0);
        if (p == 3 && i == 50) wait_idle();
      end
    end
  endtask

  initial begin
    forever begin
      if (idle_en && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    point_t exp_p;
    if (out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d z=%0d", $time, x_pos, y_pos, z_pos);
        errors++;
      end else begin
        exp_p = expected_points.pop_front();
        if (x_pos !== exp_p.x) begin
          $display("%0t: x_pos expected %0d actual %0d", $time, exp_p.x, x_pos);
          errors++;
        end
        if (y_pos !== exp_p.y) begin
          $display("%0t: y_pos expected %0d actual %0d", $time, exp_p.y, y_pos);
          errors++;
        end
        if (z_pos !== exp_p.z) begin
          $display("%0t: z_pos expected %0d actual %0d", $time, exp_p.z, z_pos);
          errors++;
        end
        if (point_valid !== exp_p.ok) begin
          $display("%0t: point_valid expected %0b actual %0b", $time, exp_p.ok, point_valid);
          errors++;
        end
        if (frame_end !== exp_p.last) begin
          $display("%0t: frame_end expected %0b actual %0b", $time, exp_p.last, frame_end);
          errors++;
        end
      end
    end
  end

  initial begin
    cam = '{frame_width: 11'd640, frame_height: 11'd480, depth_gain: 16'd3219,
            depth_offset: 24'd3491758, near_offset: -10'sd10, lateral_scale: 16'd35232};
    col_cnt = 0;
    row_cnt = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_camera();
    test_extremes();
    test_random_frames(10);
    wait_idle();
    if (errors == 0) begin
      $display("depth_to_point_cloud_core test passed");
    end else begin
      $display("depth_to_point_cloud_core test failed");
    end
    $finish;
  end

endmodule
